### rtl/lanc_frame_engine_unit_macros.svh
// assertion macros shared by the frame engine rtl
`ifndef LANC_FRAME_ENGINE_UNIT_MACROS_SVH
`define LANC_FRAME_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define LFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lfe check failed");

// next-cycle implication, checked at every rising edge outside reset
`define LFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lfe check failed");

`endif

### rtl/lfe_pkg.sv
// ----------------------------------------------------------------------------
// lfe_pkg
// shared types and constants of the lanc frame engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfe_pkg;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CMD_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CMD_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS = 2'd3;

	// register reset values
	localparam logic [11:0] BIT_TICKS_RST  = 12'd104;
	localparam logic [15:0] IDLE_TICKS_RST = 16'd3000;

	localparam logic [15:0] TICK_MAX = 16'hffff;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_WAIT  = 3'd1,
		PH_START = 3'd2,
		PH_DATA  = 3'd3,
		PH_STOP  = 3'd4
	} phase_t;

	// first received byte of a frame and last byte of a frame
	localparam logic [2:0] BYTE_FIRST_RX = 3'd4;
	localparam logic [2:0] BYTE_LAST    = 3'd7;
	localparam logic [2:0] BIT_LAST     = 3'd7;

endpackage

### rtl/lfe_if.sv
// ----------------------------------------------------------------------------
// lfe_if
// valid/ready channels of the lanc frame engine: line samples and results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfe_line_if;
	logic valid;
	logic ready;
	logic line_level;

	modport source (output valid, output line_level, input ready);
	modport sink (input valid, input line_level, output ready);
endinterface

interface lfe_result_if;
	logic       valid;
	logic       ready;
	logic       drive_level;
	logic       frame_done;
	logic [7:0] reply_byte4;
	logic [7:0] reply_byte5;
	logic [7:0] reply_byte6;
	logic [7:0] reply_byte7;

	modport source (
		output valid, output drive_level, output frame_done,
		output reply_byte4, output reply_byte5, output reply_byte6, output reply_byte7,
		input ready
	);
	modport sink (
		input valid, input drive_level, input frame_done,
		input reply_byte4, input reply_byte5, input reply_byte6, input reply_byte7,
		output ready
	);
endinterface

### rtl/lanc_frame_engine_unit.sv
// result: the result word of a line sample is registered and valid in the cycle after the sample is accepted
// throughput: one line sample per cycle; the single output register takes a new word
// in the same cycle its old word is taken, so the line side stalls only on result stall
// reset (arst_n low): idle detection, counters and reply bytes cleared, registers at
// their reset values (bit_ticks 104, idle_ticks 3000), no result word pending
// ----------------------------------------------------------------------------
// lanc_frame_engine_unit
// tick-driven lanc style frame engine: idle gap detection, four transmitted
// bytes and four received bytes per eight-byte frame
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lanc_frame_engine_unit_macros.svh"

module lanc_frame_engine_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lfe_pkg::CFG_DATA_W-1:0]      cfg_data,
	lfe_line_if.sink                            line_ch,
	lfe_result_if.source                        result_ch
);

	// configuration registers
	logic [7:0]  cmd_first_q;
	logic [7:0]  cmd_second_q;
	logic [11:0] bit_ticks_q;
	logic [15:0] idle_ticks_q;

	// frame state
	lfe_pkg::phase_t phase_q, nx_phase;
	logic [2:0]  byte_index_q, nx_byte_index;
	logic [2:0]  bit_index_q, nx_bit_index;
	logic [15:0] tick_count_q, nx_tick_count;
	logic [7:0]  shift_q, nx_shift;
	logic        drive_q, nx_drive;
	logic [7:0]  reply_q [4];
	logic [7:0]  nx_reply [4];
	logic        nx_done;

	// output register
	logic        out_valid_q;
	logic        out_drive_q;
	logic        out_done_q;
	logic [7:0]  out_reply_q [4];

	// working values
	logic        line_fire;
	logic        line;
	logic [15:0] tick_inc;
	logic [15:0] idle_cnt;
	logic [10:0] half;
	logic [15:0] half_ext;
	logic [15:0] bit_ticks_ext;
	logic        bit_end;
	logic        rx_byte;
	logic [2:0]  bit_next;

	// the output register frees up when its word is taken, so a new sample
	// can enter every cycle while the result side keeps pace
	assign line_ch.ready = !out_valid_q || result_ch.ready;
	assign line_fire     = line_ch.valid && line_ch.ready;
	assign line          = line_ch.line_level;

	assign half          = bit_ticks_q[11:1];
	assign half_ext      = {5'd0, half};
	assign bit_ticks_ext = {4'd0, bit_ticks_q};
	assign tick_inc      = tick_count_q + 16'd1;
	assign bit_end       = (tick_inc >= bit_ticks_ext);
	assign rx_byte       = (byte_index_q >= lfe_pkg::BYTE_FIRST_RX);
	assign bit_next      = bit_index_q + 3'd1;

	// idle detection counter: cleared by a low sample, saturating otherwise
	always_comb begin
		if (!line) begin
			idle_cnt = '0;
		end else if (tick_count_q != lfe_pkg::TICK_MAX) begin
			idle_cnt = tick_inc;
		end else begin
			idle_cnt = tick_count_q;
		end
	end

	// next state of the frame engine for the sample on the line channel
	always_comb begin
		nx_phase      = phase_q;
		nx_byte_index = byte_index_q;
		nx_bit_index  = bit_index_q;
		nx_tick_count = tick_count_q;
		nx_shift      = shift_q;
		nx_drive      = drive_q;
		nx_done       = 1'b0;
		for (int i = 0; i < 4; i++) begin
			nx_reply[i] = reply_q[i];
		end

		case (phase_q)
			lfe_pkg::PH_IDLE: begin
				if (idle_cnt >= idle_ticks_q) begin
					nx_phase      = lfe_pkg::PH_WAIT;
					nx_byte_index = '0;
					nx_tick_count = '0;
				end else begin
					nx_tick_count = idle_cnt;
				end
			end
			lfe_pkg::PH_WAIT: begin
				// falling edge: start bit begins, transmit byte is latched here
				if (!line) begin
					nx_phase      = lfe_pkg::PH_START;
					nx_tick_count = '0;
					nx_bit_index  = '0;
					case (byte_index_q)
						3'd0:    nx_shift = cmd_first_q;
						3'd1:    nx_shift = cmd_second_q;
						default: nx_shift = '0;
					endcase
				end
			end
			lfe_pkg::PH_START: begin
				if (bit_end) begin
					// first data bit
					nx_phase      = lfe_pkg::PH_DATA;
					nx_bit_index  = '0;
					nx_tick_count = '0;
					if (!rx_byte) begin
						nx_drive = shift_q[0];
					end else if (half == '0 && line) begin
						nx_shift = shift_q | 8'd1;
					end
				end else begin
					nx_tick_count = tick_inc;
				end
			end
			lfe_pkg::PH_DATA: begin
				if (bit_end) begin
					nx_tick_count = '0;
					if (bit_index_q == lfe_pkg::BIT_LAST) begin
						// byte complete: release the line and store a received byte
						nx_drive = 1'b0;
						if (rx_byte) begin
							nx_reply[byte_index_q[1:0]] = shift_q;
						end
						if (byte_index_q == lfe_pkg::BYTE_LAST) begin
							nx_done       = 1'b1;
							nx_phase      = lfe_pkg::PH_IDLE;
							nx_byte_index = '0;
						end else begin
							nx_byte_index = byte_index_q + 3'd1;
							nx_phase      = (half == '0) ? lfe_pkg::PH_WAIT : lfe_pkg::PH_STOP;
						end
					end else begin
						nx_bit_index = bit_next;
						if (!rx_byte) begin
							nx_drive = shift_q[bit_next];
						end else if (half == '0 && line) begin
							nx_shift = shift_q | (8'd1 << bit_next);
						end
					end
				end else begin
					nx_tick_count = tick_inc;
					// mid-bit sample of a received bit
					if (rx_byte && tick_inc == half_ext && line) begin
						nx_shift = shift_q | (8'd1 << bit_index_q);
					end
				end
			end
			lfe_pkg::PH_STOP: begin
				// half-bit wait after the byte before looking for the next edge
				if (tick_inc >= half_ext) begin
					nx_phase      = lfe_pkg::PH_WAIT;
					nx_tick_count = '0;
				end else begin
					nx_tick_count = tick_inc;
				end
			end
			default: begin
				nx_phase      = lfe_pkg::PH_IDLE;
				nx_tick_count = '0;
			end
		endcase
	end

	// configuration registers; the user must write them only while the engine is quiet, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_first_q  <= '0;
			cmd_second_q <= '0;
			bit_ticks_q  <= lfe_pkg::BIT_TICKS_RST;
			idle_ticks_q <= lfe_pkg::IDLE_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lfe_pkg::REG_CMD_FIRST:  cmd_first_q  <= cfg_data[7:0];
				lfe_pkg::REG_CMD_SECOND: cmd_second_q <= cfg_data[7:0];
				lfe_pkg::REG_BIT_TICKS:  bit_ticks_q  <= cfg_data[11:0];
				lfe_pkg::REG_IDLE_TICKS: idle_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// frame state advances once per accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= lfe_pkg::PH_IDLE;
			byte_index_q <= '0;
			bit_index_q  <= '0;
			tick_count_q <= '0;
			shift_q      <= '0;
			drive_q      <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				reply_q[i] <= '0;
			end
		end else if (line_fire) begin
			phase_q      <= nx_phase;
			byte_index_q <= nx_byte_index;
			bit_index_q  <= nx_bit_index;
			tick_count_q <= nx_tick_count;
			shift_q      <= nx_shift;
			drive_q      <= nx_drive;
			for (int i = 0; i < 4; i++) begin
				reply_q[i] <= nx_reply[i];
			end
		end
	end

	// result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (line_fire) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (line_fire) begin
			out_drive_q <= nx_drive;
			out_done_q  <= nx_done;
			for (int i = 0; i < 4; i++) begin
				out_reply_q[i] <= nx_reply[i];
			end
		end
	end

	assign result_ch.valid       = out_valid_q;
	assign result_ch.drive_level = out_drive_q;
	assign result_ch.frame_done  = out_done_q;
	assign result_ch.reply_byte4 = out_reply_q[0];
	assign result_ch.reply_byte5 = out_reply_q[1];
	assign result_ch.reply_byte6 = out_reply_q[2];
	assign result_ch.reply_byte7 = out_reply_q[3];

	// the pin is only driven inside data bits
	`LFE_ASSERT_NOW(a_drive_in_data, clk, arst_n, phase_q != lfe_pkg::PH_DATA, !drive_q)
	// a frame end releases the pin
	`LFE_ASSERT_NOW(a_done_released, clk, arst_n, out_valid_q && out_done_q, !out_drive_q)
	// idle detection always restarts the frame at byte zero
	`LFE_ASSERT_NOW(a_idle_byte_zero, clk, arst_n, phase_q == lfe_pkg::PH_IDLE, byte_index_q == '0)
	// every accepted sample yields a pending result word
	`LFE_ASSERT_NEXT(a_fire_result, clk, arst_n, line_fire, out_valid_q)

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lanc frame engine: line samples are fed one
// word per tick as idle gaps, eight-byte frames and random line levels, a
// tick-level predictor tracks the engine, and every result word is compared
// field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic            drive_level;
		logic            frame_done;
		logic [3:0][7:0] reply;      // reply[0] is frame byte 4
	} engine_word_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [lfe_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lfe_pkg::CFG_DATA_W-1:0] cfg_data;

	lfe_line_if   line_ch ();
	lfe_result_if result_ch ();

	lanc_frame_engine_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.line_ch   (line_ch),
		.result_ch (result_ch)
	);

	// register copies
	logic [7:0]  set_cmd_first  = 8'd0;
	logic [7:0]  set_cmd_second = 8'd0;
	logic [11:0] set_bit_ticks  = lfe_pkg::BIT_TICKS_RST;
	logic [15:0] set_idle_ticks = lfe_pkg::IDLE_TICKS_RST;

	// predicted engine state
	lfe_pkg::phase_t eng_phase = lfe_pkg::PH_IDLE;
	logic [2:0]  eng_byte  = 3'd0;
	logic [15:0] eng_ticks = 16'd0;
	logic [7:0]  eng_shift = 8'd0;
	logic [3:0]  eng_bit   = 4'd0;
	logic        eng_drive = 1'b0;
	logic [3:0][7:0] eng_reply = '0;

	engine_word_t pending_words[$];

	int mismatch_count = 0;
	int ticks_sent     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int hold_left      = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// first tick of a data bit: a transmit bit goes out at once, a receive bit
	// with no half-bit offset is sampled here
	function void open_bit(input logic lvl);
		logic [10:0] half;
		half = set_bit_ticks[11:1];
		eng_ticks = 16'd0;
		if (eng_byte < lfe_pkg::BYTE_FIRST_RX)
			eng_drive = eng_shift[eng_bit[2:0]];
		else if (half == 11'd0 && lvl)
			eng_shift[eng_bit[2:0]] = 1'b1;
	endfunction

	// one line sample through the engine; queues the result word it causes
	function void advance_engine(input logic lvl);
		logic [10:0]  half;
		logic         done;
		engine_word_t word;
		half = set_bit_ticks[11:1];
		done = 1'b0;
		case (eng_phase)
			lfe_pkg::PH_IDLE: begin
				if (!lvl)
					eng_ticks = 16'd0;
				else if (eng_ticks != lfe_pkg::TICK_MAX)
					eng_ticks = eng_ticks + 16'd1;
				if (eng_ticks >= set_idle_ticks) begin
					eng_phase = lfe_pkg::PH_WAIT;
					eng_byte  = 3'd0;
					eng_ticks = 16'd0;
				end
			end
			lfe_pkg::PH_WAIT: begin
				// falling edge: load the transmit byte from the registers now
				if (!lvl) begin
					eng_phase = lfe_pkg::PH_START;
					eng_ticks = 16'd0;
					eng_bit   = 4'd0;
					if (eng_byte == 3'd0)
						eng_shift = set_cmd_first;
					else if (eng_byte == 3'd1)
						eng_shift = set_cmd_second;
					else
						eng_shift = 8'd0;
				end
			end
			lfe_pkg::PH_START: begin
				eng_ticks = eng_ticks + 16'd1;
				if (eng_ticks >= set_bit_ticks) begin
					eng_phase = lfe_pkg::PH_DATA;
					eng_bit   = 4'd0;
					open_bit(lvl);
				end
			end
			lfe_pkg::PH_DATA: begin
				eng_ticks = eng_ticks + 16'd1;
				if (eng_ticks >= set_bit_ticks) begin
					eng_bit = eng_bit + 4'd1;
					if (eng_bit > lfe_pkg::BIT_LAST) begin
						eng_drive = 1'b0;
						eng_ticks = 16'd0;
						// bytes 4..7 land in reply slots 0..3
						if (eng_byte >= lfe_pkg::BYTE_FIRST_RX)
							eng_reply[eng_byte[1:0]] = eng_shift;
						if (eng_byte == lfe_pkg::BYTE_LAST) begin
							done      = 1'b1;
							eng_phase = lfe_pkg::PH_IDLE;
							eng_byte  = 3'd0;
						end else begin
							eng_byte  = eng_byte + 3'd1;
							eng_phase = (half == 11'd0) ? lfe_pkg::PH_WAIT : lfe_pkg::PH_STOP;
						end
					end else begin
						open_bit(lvl);
					end
				end else if (eng_byte >= lfe_pkg::BYTE_FIRST_RX && eng_ticks == half && lvl) begin
					eng_shift[eng_bit[2:0]] = 1'b1;
				end
			end
			lfe_pkg::PH_STOP: begin
				eng_ticks = eng_ticks + 16'd1;
				if (eng_ticks >= half) begin
					eng_phase = lfe_pkg::PH_WAIT;
					eng_ticks = 16'd0;
				end
			end
			default: begin
				eng_phase = lfe_pkg::PH_IDLE;
				eng_ticks = 16'd0;
			end
		endcase
		word.drive_level = eng_drive;
		word.frame_done  = done;
		word.reply       = eng_reply;
		pending_words.push_back(word);
	endfunction

	// ---------------------------------------------------------------- result side

	task automatic note_mismatch(input string field, input logic [7:0] want,
			input logic [7:0] got);
		mismatch_count++;
		$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
	endtask

	task automatic check_word();
		engine_word_t got;
		engine_word_t want;
		int i;
		got.drive_level = result_ch.drive_level;
		got.frame_done  = result_ch.frame_done;
		got.reply[0]    = result_ch.reply_byte4;
		got.reply[1]    = result_ch.reply_byte5;
		got.reply[2]    = result_ch.reply_byte6;
		got.reply[3]    = result_ch.reply_byte7;
		if (pending_words.size() == 0) begin
			mismatch_count++;
			$display("%0t: result word expected none actual %0h", $time, got);
		end else begin
			want = pending_words.pop_front();
			if (got.drive_level !== want.drive_level)
				note_mismatch("drive_level", {7'd0, want.drive_level},
					{7'd0, got.drive_level});
			if (got.frame_done !== want.frame_done)
				note_mismatch("frame_done", {7'd0, want.frame_done},
					{7'd0, got.frame_done});
			for (i = 0; i < 4; i++)
				if (got.reply[i] !== want.reply[i])
					note_mismatch($sformatf("reply_byte%0d", i + 4), want.reply[i],
						got.reply[i]);
		end
	endtask

	// receiver: random stalls, plus a counted hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready)
				check_word();
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------- line side

	task automatic send_tick(input logic lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			line_ch.valid <= 1'b0;
			@(posedge clk);
		end
		line_ch.valid      <= 1'b1;
		line_ch.line_level <= lvl;
		do @(posedge clk); while (!line_ch.ready);
		advance_engine(lvl);
		ticks_sent++;
	endtask

	task automatic send_run(input logic lvl, input int n);
		int k;
		for (k = 0; k < n; k++)
			send_tick(lvl);
	endtask

	// stop offering words and wait until every result word has come back
	task automatic drain();
		line_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// writes all four registers, one per edge; call only when drained
	task automatic program_engine(input logic [7:0] first, input logic [7:0] second,
			input logic [11:0] bit_len, input logic [15:0] gap_len);
		cfg_we    <= 1'b1;
		cfg_index <= lfe_pkg::REG_CMD_FIRST;
		cfg_data  <= {8'd0, first};
		@(posedge clk);
		set_cmd_first = first;
		cfg_index <= lfe_pkg::REG_CMD_SECOND;
		cfg_data  <= {8'd0, second};
		@(posedge clk);
		set_cmd_second = second;
		cfg_index <= lfe_pkg::REG_BIT_TICKS;
		cfg_data  <= {4'd0, bit_len};
		@(posedge clk);
		set_bit_ticks = bit_len;
		cfg_index <= lfe_pkg::REG_IDLE_TICKS;
		cfg_data  <= gap_len;
		@(posedge clk);
		set_idle_ticks = gap_len;
		cfg_we <= 1'b0;
	endtask

	// random line levels until the engine is back in idle detection
	task automatic settle_to_idle();
		while (eng_phase != lfe_pkg::PH_IDLE)
			send_tick(1'($urandom_range(1)));
	endtask

	// idle gap then n_bytes bytes of a frame; noisy adds a low that restarts
	// the gap count and lows inside each stop wait, which must be ignored
	task automatic send_frame(input logic [3:0][7:0] rx, input int n_bytes,
			input bit noisy);
		int   bt;
		int   half;
		int   b;
		int   i;
		int   k;
		logic lvl;
		bt   = set_bit_ticks;
		half = bt / 2;
		if (noisy) begin
			send_run(1'b1, set_idle_ticks / 2);
			send_tick(1'b0);
		end
		send_run(1'b1, set_idle_ticks + $urandom_range(0, 3));
		for (b = 0; b < n_bytes; b++) begin
			// falling edge and rest of the start bit
			send_run(1'b0, bt);
			for (i = 0; i < 8; i++) begin
				lvl = (b >= lfe_pkg::BYTE_FIRST_RX) ? rx[b - lfe_pkg::BYTE_FIRST_RX][i]
					: 1'($urandom_range(1));
				send_run(lvl, bt);
			end
			// tick that closes the byte
			send_tick(1'b1);
			if (b < lfe_pkg::BYTE_LAST) begin
				for (k = 1; k <= half; k++)
					send_tick(!(noisy && k == 1));
				send_run(1'b1, $urandom_range(0, 3));
			end
		end
	endtask

	// ---------------------------------------------------------------- tests

	// register reset values: long gap length keeps the engine in idle detection
	task automatic test_reset_values();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_run(1'b1, 24);
		send_tick(1'b0);
		send_run(1'b1, 8);
		drain();
	endtask

	// short bit and gap lengths, extreme command bytes, noisy whole frame
	task automatic test_edge_settings();
		program_engine(8'hFF, 8'h00, 12'd4, 16'd1);
		send_frame({8'hC3, 8'h3C, 8'h00, 8'hFF}, 8, 1'b1);
		drain();
	endtask

	// longest gap, with a low that restarts the count, then a short gap
	task automatic test_long_gap();
		program_engine(8'h12, 8'h34, 12'd4, 16'hFFFF);
		send_run(1'b1, 40);
		send_tick(1'b0);
		send_run(1'b1, 40);
		drain();
		program_engine(8'h12, 8'h34, 12'd4, 16'd1);
	endtask

	// longest bit: part of a start bit, the frame goes on at short bits later
	task automatic test_long_bit_time();
		program_engine(8'hA5, 8'h5A, 12'd4095, 16'd1);
		send_run(1'b1, 2);
		send_run(1'b0, 40);
		drain();
	endtask

	// receiver holds off for a long stretch while the line side keeps offering
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		program_engine(8'h5A, 8'hA5, 12'd4, 16'd3);
		hold_req = 300;
		settle_to_idle();
		drain();
	endtask

	// random line levels with occasional register changes
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int n_ticks);
		int first_tick;
		int pick;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		first_tick     = ticks_sent;
		while (ticks_sent - first_tick < n_ticks) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				drain();
				program_engine(8'($urandom_range(255)), 8'($urandom_range(255)),
					12'($urandom_range(4, 6)), 16'($urandom_range(1, 8)));
			end else begin
				send_run(1'($urandom_range(1)), int'($urandom_range(1, 12)));
			end
		end
		drain();
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = lfe_pkg::REG_CMD_FIRST;
		cfg_data           = '0;
		line_ch.valid      = 1'b0;
		line_ch.line_level = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_edge_settings();
		test_long_gap();
		test_long_bit_time();
		test_backpressure();
		test_random_traffic(0, 0, 40);
		test_random_traffic(72, 0, 40);
		test_random_traffic(0, 72, 40);
		test_random_traffic(9, 9, 40);

		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_words.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/lfe_pkg.sv
rtl/lfe_if.sv
rtl/lanc_frame_engine_unit.sv
sim/tb_top.sv
